// ===== src/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, constants and keyword tables of the SQL token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int PosBits = 16;
  localparam int MaxRes = 8;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_IDENT   = 4'd1,
    M_INT     = 4'd2,
    M_STR     = 4'd3,
    M_STRQ    = 4'd4,
    M_LT      = 4'd5,
    M_GT      = 4'd6,
    M_BANG    = 4'd7,
    M_MINUS   = 4'd8,
    M_COMMENT = 4'd9
  } mode_t;

  localparam logic [4:0] T_EOF     = 5'd0;
  localparam logic [4:0] T_IDENT   = 5'd1;
  localparam logic [4:0] T_INT     = 5'd2;
  localparam logic [4:0] T_STR     = 5'd3;
  localparam logic [4:0] T_STAR    = 5'd4;
  localparam logic [4:0] T_COMMA   = 5'd5;
  localparam logic [4:0] T_SEMI    = 5'd6;
  localparam logic [4:0] T_LPAREN  = 5'd7;
  localparam logic [4:0] T_RPAREN  = 5'd8;
  localparam logic [4:0] T_EQ      = 5'd9;
  localparam logic [4:0] T_LT      = 5'd10;
  localparam logic [4:0] T_LTE     = 5'd11;
  localparam logic [4:0] T_GT      = 5'd12;
  localparam logic [4:0] T_GTE     = 5'd13;
  localparam logic [4:0] T_NEQ     = 5'd14;
  localparam logic [4:0] T_UNKNOWN = 5'd15;
  localparam logic [4:0] T_KW0     = 5'd16;

  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChEq    = 8'h3D;

  // One result record
  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
    logic [4:0] token_type;
    logic [15:0] first_line;
    logic [15:0] start_column;
    logic        run_last;
  } res_t;

  // Up to eight results produced by one input byte
  typedef struct packed {
    logic [3:0]             count;
    res_t [MaxRes-1:0]      res;
  } batch_t;

  // Keyword length
  function automatic logic [3:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0: kw_len = 4'd6;  4'd1: kw_len = 4'd4;  4'd2: kw_len = 4'd5;
      4'd3: kw_len = 4'd6;  4'd4: kw_len = 4'd4;  4'd5: kw_len = 4'd6;
      4'd6: kw_len = 4'd6;  4'd7: kw_len = 4'd5;  4'd8: kw_len = 4'd7;
      4'd9: kw_len = 4'd3;  4'd10: kw_len = 4'd3; 4'd11: kw_len = 4'd2;
      4'd12: kw_len = 4'd3; 4'd13: kw_len = 4'd3; 4'd14: kw_len = 4'd7;
      default: kw_len = 4'd4;
    endcase
  endfunction

  // Keyword text, 8 characters each (NUL padded)
  function automatic logic [63:0] kw_text(input logic [3:0] k);
    case (k)
      4'd0:  kw_text = {"SELECT", 16'h0};
      4'd1:  kw_text = {"FROM", 32'h0};
      4'd2:  kw_text = {"WHERE", 24'h0};
      4'd3:  kw_text = {"INSERT", 16'h0};
      4'd4:  kw_text = {"INTO", 32'h0};
      4'd5:  kw_text = {"VALUES", 16'h0};
      4'd6:  kw_text = {"CREATE", 16'h0};
      4'd7:  kw_text = {"TABLE", 24'h0};
      4'd8:  kw_text = {"PRIMARY", 8'h0};
      4'd9:  kw_text = {"KEY", 40'h0};
      4'd10: kw_text = {"AND", 40'h0};
      4'd11: kw_text = {"OR", 48'h0};
      4'd12: kw_text = {"NOT", 40'h0};
      4'd13: kw_text = {"INT", 40'h0};
      4'd14: kw_text = {"VARCHAR", 8'h0};
      default: kw_text = {"NULL", 32'h0};
    endcase
  endfunction

  // Character at position idx (0 = first) of keyword k
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] idx);
    logic [63:0] t;
    t = kw_text(k);
    kw_char = t[63 - 8*idx -: 8];
  endfunction

endpackage

// ===== src/sql_token_lexer.sv =====
// ----------------------------------------------------------------------------
// sql_token_lexer
// Streaming SQL tokenizer: one source byte in, zero to eight results out.
// ----------------------------------------------------------------------------
// Pipeline: the results of a byte are registered in the two-entry batch queue, then sent
// by the result sequencer. Throughput: one byte per cycle in while the queue has room; one
//   result per cycle out while m_tready is high. New bytes are taken while a batch is being sent.
// Reset: rst clears scanner state to line 1, column 1 and empties the queue.
module sql_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] text_byte, [12:8] token_type,
                                 // [28:13] start_line, [44:29] start_column
  output logic        m_tuser,   // kind
  output logic        m_tlast    // run_last
);

  logic            fq_valid, fq_ready;
  stl_pkg::batch_t fq_batch;
  logic            qb_valid, qb_ready;
  stl_pkg::batch_t qb_batch;
  stl_pkg::res_t   res;

  stl_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .byte_in(s_tdata), .end_of_input(s_tlast),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_batch(fq_batch)
  );

  stl_queue u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_batch(fq_batch),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_batch(qb_batch)
  );

  stl_back u_back (
    .clk, .rst,
    .b_valid(qb_valid), .b_ready(qb_ready), .b_batch(qb_batch),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {3'b000, res.start_column, res.first_line, res.token_type, res.text_byte};
  assign m_tuser = res.kind;
  assign m_tlast = res.run_last;

endmodule

// ===== src/stl_front.sv =====
// ----------------------------------------------------------------------------
// stl_front
// Scanner state machine: classifies each byte and builds its batch of results.
// ----------------------------------------------------------------------------
module stl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          byte_in,
  input  logic                end_of_input,
  output logic                q_valid,
  input  logic                q_ready,
  output stl_pkg::batch_t     q_batch
);

  localparam logic [stl_pkg::PosBits-1:0] PosMax = '1;
  localparam logic [stl_pkg::PosBits-1:0] PosBits1 = 1;

  stl_pkg::mode_t              mode, mode_next;
  logic [stl_pkg::PosBits-1:0] cur_line, cur_line_next;
  logic [stl_pkg::PosBits-1:0] cur_col, cur_col_next;
  logic [stl_pkg::PosBits-1:0] tok_line, tok_line_next;
  logic [stl_pkg::PosBits-1:0] tok_col, tok_col_next;
  logic [15:0]                 cand, cand_next;
  logic [3:0]                  wlen, wlen_next;
  stl_pkg::batch_t             batch;
  logic                        take;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign q_batch  = batch;
  assign take     = in_valid && q_ready;

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= "0" && c <= "9";
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    is_space = c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Reset state on rst or advance on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= stl_pkg::M_IDLE;
      cur_line <= PosBits1;
      cur_col  <= PosBits1;
      tok_line <= PosBits1;
      tok_col  <= PosBits1;
      cand     <= '1;
      wlen     <= '0;
    end else if (take) begin
      mode     <= mode_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      cand     <= cand_next;
      wlen     <= wlen_next;
    end
  end

  // Scan one byte
  always_comb begin
    logic        consumed;
    logic [7:0]  up;
    logic [4:0]  single;
    logic [4:0]  wtype;
    logic        found;
    logic [3:0]  n;
    mode_next     = mode;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    cand_next     = cand;
    wlen_next     = wlen;
    batch         = '0;
    consumed      = 1'b0;
    single        = stl_pkg::T_UNKNOWN;
    n             = '0;
    up            = (byte_in >= "a" && byte_in <= "z") ? byte_in - 8'd32 : byte_in;

    // word type from current candidates
    wtype = stl_pkg::T_IDENT;
    found = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (!found && cand[k] && stl_pkg::kw_len(4'(k)) == wlen) begin
        wtype = stl_pkg::T_KW0 + 5'(k);
        found = 1'b1;
      end
    end

    // continue an open token
    case (mode)
      stl_pkg::M_IDENT: begin
        if (is_alpha(byte_in) || is_digit(byte_in) || byte_in == "_") begin
          consumed = 1'b1;
          batch.res[n[2:0]].text_byte = byte_in; n = n + 4'd1;
        end else begin
          batch.res[n[2:0]].kind = 1'b1; batch.res[n[2:0]].token_type = wtype;
          batch.res[n[2:0]].first_line = 16'(tok_line);
          batch.res[n[2:0]].start_column = 16'(tok_col);
          n = n + 4'd1; mode_next = stl_pkg::M_IDLE;
        end
      end
      stl_pkg::M_INT: begin
        if (is_digit(byte_in)) begin
          consumed = 1'b1;
          batch.res[n[2:0]].text_byte = byte_in; n = n + 4'd1;
        end else begin
          batch.res[n[2:0]].kind = 1'b1; batch.res[n[2:0]].token_type = stl_pkg::T_INT;
          batch.res[n[2:0]].first_line = 16'(tok_line);
          batch.res[n[2:0]].start_column = 16'(tok_col);
          n = n + 4'd1; mode_next = stl_pkg::M_IDLE;
        end
      end
      stl_pkg::M_STR: begin
        consumed = 1'b1;
        if (byte_in == stl_pkg::ChQuote) mode_next = stl_pkg::M_STRQ;
        else begin
          batch.res[n[2:0]].text_byte = byte_in; n = n + 4'd1;
        end
      end
      stl_pkg::M_STRQ: begin
        if (byte_in == stl_pkg::ChQuote) begin
          consumed = 1'b1; mode_next = stl_pkg::M_STR;
          batch.res[n[2:0]].text_byte = byte_in; n = n + 4'd1;
        end else begin
          batch.res[n[2:0]].kind = 1'b1; batch.res[n[2:0]].token_type = stl_pkg::T_STR;
          batch.res[n[2:0]].first_line = 16'(tok_line);
          batch.res[n[2:0]].start_column = 16'(tok_col);
          n = n + 4'd1; mode_next = stl_pkg::M_IDLE;
        end
      end
      stl_pkg::M_LT, stl_pkg::M_GT, stl_pkg::M_BANG: begin
        mode_next = stl_pkg::M_IDLE;
        if (byte_in == stl_pkg::ChEq) begin
          consumed = 1'b1;
          batch.res[n[2:0]].text_byte = byte_in; n = n + 4'd1;
        end
        batch.res[n[2:0]].kind = 1'b1;
        batch.res[n[2:0]].first_line = 16'(tok_line);
        batch.res[n[2:0]].start_column = 16'(tok_col);
        if (mode == stl_pkg::M_LT)
          batch.res[n[2:0]].token_type = consumed ? stl_pkg::T_LTE : stl_pkg::T_LT;
        else if (mode == stl_pkg::M_GT)
          batch.res[n[2:0]].token_type = consumed ? stl_pkg::T_GTE : stl_pkg::T_GT;
        else
          batch.res[n[2:0]].token_type = consumed ? stl_pkg::T_NEQ : stl_pkg::T_UNKNOWN;
        n = n + 4'd1;
      end
      stl_pkg::M_MINUS: begin
        if (byte_in == stl_pkg::ChMinus) begin
          consumed = 1'b1; mode_next = stl_pkg::M_COMMENT;
        end else begin
          batch.res[n[2:0]].text_byte = stl_pkg::ChMinus; n = n + 4'd1;
          batch.res[n[2:0]].kind = 1'b1;
          batch.res[n[2:0]].token_type = stl_pkg::T_UNKNOWN;
          batch.res[n[2:0]].first_line = 16'(tok_line);
          batch.res[n[2:0]].start_column = 16'(tok_col);
          n = n + 4'd1; mode_next = stl_pkg::M_IDLE;
        end
      end
      stl_pkg::M_COMMENT: begin
        if (byte_in == stl_pkg::ChNl) mode_next = stl_pkg::M_IDLE;
        else consumed = 1'b1;
      end
      default: mode_next = stl_pkg::M_IDLE;
    endcase

    // update keyword candidates on a word character
    if (mode == stl_pkg::M_IDENT && consumed) begin
      for (int k = 0; k < 16; k++)
        if (wlen >= stl_pkg::kw_len(4'(k)) || stl_pkg::kw_char(4'(k), wlen[2:0]) != up)
          cand_next[k] = 1'b0;
      if (wlen < 4'd15) wlen_next = wlen + 4'd1;
    end

    // start a new token
    if (!consumed && !is_space(byte_in)) begin
      tok_line_next = cur_line;
      tok_col_next  = cur_col;
      if (is_alpha(byte_in) || byte_in == "_") begin
        mode_next = stl_pkg::M_IDENT;
        for (int k = 0; k < 16; k++)
          cand_next[k] = stl_pkg::kw_char(4'(k), 3'd0) == up;
        wlen_next = 4'd1;
        batch.res[n[2:0]].text_byte = byte_in; n = n + 4'd1;
      end else if (byte_in == stl_pkg::ChMinus) begin
        mode_next = stl_pkg::M_MINUS;
      end else if (byte_in == stl_pkg::ChQuote) begin
        mode_next = stl_pkg::M_STR;
      end else if (byte_in == stl_pkg::ChLt || byte_in == stl_pkg::ChGt
                   || byte_in == stl_pkg::ChBang || is_digit(byte_in)) begin
        batch.res[n[2:0]].text_byte = byte_in; n = n + 4'd1;
        if (byte_in == stl_pkg::ChLt) mode_next = stl_pkg::M_LT;
        else if (byte_in == stl_pkg::ChGt) mode_next = stl_pkg::M_GT;
        else if (byte_in == stl_pkg::ChBang) mode_next = stl_pkg::M_BANG;
        else mode_next = stl_pkg::M_INT;
      end else begin
        case (byte_in)
          "*": single = stl_pkg::T_STAR;
          ",": single = stl_pkg::T_COMMA;
          ";": single = stl_pkg::T_SEMI;
          "(": single = stl_pkg::T_LPAREN;
          ")": single = stl_pkg::T_RPAREN;
          "=": single = stl_pkg::T_EQ;
          default: single = stl_pkg::T_UNKNOWN;
        endcase
        batch.res[n[2:0]].text_byte = byte_in; n = n + 4'd1;
        batch.res[n[2:0]].kind = 1'b1; batch.res[n[2:0]].token_type = single;
        batch.res[n[2:0]].first_line = 16'(cur_line);
        batch.res[n[2:0]].start_column = 16'(cur_col);
        n = n + 4'd1; mode_next = stl_pkg::M_IDLE;
      end
    end

    // advance position
    if (byte_in == stl_pkg::ChNl) begin
      if (cur_line < PosMax) cur_line_next = cur_line + PosBits1;
      cur_col_next = PosBits1;
    end else if (cur_col < PosMax) begin
      cur_col_next = cur_col + PosBits1;
    end

    // close an open token and emit EOF on the last byte
    if (end_of_input) begin
      // keyword type with the candidates after this byte
      wtype = stl_pkg::T_IDENT;
      found = 1'b0;
      for (int k = 0; k < 16; k++) begin
        if (!found && cand_next[k] && stl_pkg::kw_len(4'(k)) == wlen_next) begin
          wtype = stl_pkg::T_KW0 + 5'(k);
          found = 1'b1;
        end
      end
      if (mode_next == stl_pkg::M_MINUS) begin
        batch.res[n[2:0]].text_byte = stl_pkg::ChMinus; n = n + 4'd1;
      end
      if (mode_next != stl_pkg::M_IDLE && mode_next != stl_pkg::M_COMMENT) begin
        batch.res[n[2:0]].kind = 1'b1;
        batch.res[n[2:0]].first_line = 16'(tok_line_next);
        batch.res[n[2:0]].start_column = 16'(tok_col_next);
        case (mode_next)
          stl_pkg::M_IDENT: batch.res[n[2:0]].token_type = wtype;
          stl_pkg::M_INT:   batch.res[n[2:0]].token_type = stl_pkg::T_INT;
          stl_pkg::M_STR, stl_pkg::M_STRQ: batch.res[n[2:0]].token_type = stl_pkg::T_STR;
          stl_pkg::M_LT:    batch.res[n[2:0]].token_type = stl_pkg::T_LT;
          stl_pkg::M_GT:    batch.res[n[2:0]].token_type = stl_pkg::T_GT;
          default:          batch.res[n[2:0]].token_type = stl_pkg::T_UNKNOWN;
        endcase
        n = n + 4'd1;
      end
      batch.res[n[2:0]].kind = 1'b1;
      batch.res[n[2:0]].token_type = stl_pkg::T_EOF;
      batch.res[n[2:0]].first_line = 16'(cur_line_next);
      batch.res[n[2:0]].start_column = 16'(cur_col_next);
      n = n + 4'd1;
      mode_next     = stl_pkg::M_IDLE;
      cur_line_next = PosBits1;
      cur_col_next  = PosBits1;
      tok_line_next = PosBits1;
      tok_col_next  = PosBits1;
      cand_next     = '1;
      wlen_next     = '0;
    end

    if (n != 4'd0) batch.res[3'(n - 4'd1)].run_last = 1'b1;
    batch.count = n;
  end

endmodule

// ===== src/stl_queue.sv =====
// ----------------------------------------------------------------------------
// stl_queue
// Two-entry batch queue between scanner and result sequencer.
// ----------------------------------------------------------------------------
module stl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  stl_pkg::batch_t wr_batch,
  output logic            rd_valid,
  input  logic            rd_ready,
  output stl_pkg::batch_t rd_batch
);

  stl_pkg::batch_t slots [2];
  logic            wptr, rptr;
  logic [1:0]      fill;
  logic            push, pop;

  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_batch = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store batch
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wr_batch;
  end

endmodule

// ===== src/stl_back.sv =====
// ----------------------------------------------------------------------------
// stl_back
// Result sequencer: sends the results of one batch, one per transaction.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            b_valid,
  output logic            b_ready,
  input  stl_pkg::batch_t b_batch,
  output logic            out_valid,
  input  logic            out_ready,
  output stl_pkg::res_t   out_res
);

  logic [2:0] idx;
  logic       empty_batch;
  logic       send;

  assign empty_batch = b_batch.count == 4'd0;
  assign out_valid   = b_valid && !empty_batch;
  assign out_res     = b_batch.res[idx];
  assign send        = out_valid && out_ready;
  assign b_ready     = empty_batch || (send && out_res.run_last);

  // Step through the batch
  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (b_valid && b_ready) idx <= '0;
    else if (send) idx <= idx + 3'd1;
  end

endmodule

// ===== src/stl_checker.sv =====
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks of the SQL token lexer.
// ----------------------------------------------------------------------------
module stl_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Text bytes carry no type or position
  a_text_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[44:8] == '0) else $error("text result not clean");

  // Text byte field is zero in end records
  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0) else $error("end record has text");

  // An EOF record closes its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && m_tdata[12:8] == 5'd0 |-> m_tlast) else $error("EOF not last");

  // Held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output changed");

endmodule

bind sql_token_lexer stl_checker u_stl_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
